@@ src/espc_pkg.sv @@
// espc_pkg: shared types, codes and constants of the encoder pi speed controller
// used by every module of the block; depends on nothing

package espc_pkg;

    localparam int CAPTURE_WIDTH = 16;
    localparam logic [31:0] CAP_MASK = 32'((64'd1 << CAPTURE_WIDTH) - 64'd1);

    localparam logic [7:0] KICK_DUTY = 8'd250;

    // divider: magnitude of the pi sum fits in 49 bits
    localparam int DIV_W = 49;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] SPEED_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] DRIVE_STEPS = STEP_W'(DIV_W);

    localparam logic [1:0] OP_EDGE = 2'd0;
    localparam logic [1:0] OP_OVF  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_CMD  = 2'd3;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_REV   = 2'd1;
    localparam logic [1:0] DIR_BRAKE = 2'd2;
    localparam logic [1:0] DIR_KEEP  = 2'd3;

    localparam logic [1:0] BR_FWD   = 2'd1;
    localparam logic [1:0] BR_REV   = 2'd2;
    localparam logic [1:0] BR_BRAKE = 2'd3;

    localparam logic [2:0] CFG_SCALE  = 3'd0;
    localparam logic [2:0] CFG_SGAIN  = 3'd1;
    localparam logic [2:0] CFG_PGAIN  = 3'd2;
    localparam logic [2:0] CFG_IGAIN  = 3'd3;
    localparam logic [2:0] CFG_DIV    = 3'd4;
    localparam logic [2:0] CFG_WINDOW = 3'd5;
    localparam logic [2:0] CFG_DMAX   = 3'd6;
    localparam logic [2:0] CFG_DMIN   = 3'd7;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_FALL = 2'd1,
        PH_RISE = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPEED,
        S_ERR,
        S_WIN,
        S_MUL,
        S_SUM,
        S_NEG,
        S_DRIVE,
        S_CLAMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_drive;
        logic err_en;
        logic win_en;
        logic mul_en;
        logic sum_en;
        logic clamp_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic win_now;
    } t_dp_stat;

endpackage

@@ src/espc_div.sv @@
// espc_div: restoring unsigned divider, one quotient bit per cycle
// uses espc_pkg for widths

module espc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [espc_pkg::STEP_W-1:0]      i_steps,
    input  logic [espc_pkg::DIV_W-1:0]       i_dividend,
    input  logic [31:0]                      i_divisor,
    output logic                             o_busy,
    output logic [espc_pkg::DIV_W-1:0]       o_quotient
);

    logic [espc_pkg::STEP_W-1:0] r_count;
    logic [espc_pkg::DIV_W-1:0]  r_dq;
    logic [31:0]                 r_rem;
    logic [31:0]                 r_div;
    logic [32:0]                 trial;
    logic [32:0]                 diff;
    logic                        ge;

    assign trial = {r_rem, r_dq[espc_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_start) begin
            r_count <= i_steps;
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_count != '0) begin
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_dq  <= {r_dq[espc_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_busy     = r_count != '0;
    assign o_quotient = r_dq;

endmodule

@@ src/espc_dp.sv @@
// espc_dp: datapath with config registers, encoder capture, pi arithmetic, result register
// uses espc_pkg and espc_div; driven by espc_ctrl commands

module espc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  espc_pkg::t_dp_cmd    i_cmd,
    output espc_pkg::t_dp_stat   o_stat,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic [15:0]          i_capture_time,
    input  logic [1:0]           i_direction_cmd,
    input  logic [7:0]           i_speed_cmd,
    output logic [7:0]           o_duty,
    output logic [1:0]           o_bridge_lines,
    output logic [31:0]          o_period,
    output logic [31:0]          o_speed_error,
    output logic                 o_in_window
);

    // config
    logic [31:0] r_scale;
    logic [15:0] r_sgain;
    logic [15:0] r_pgain;
    logic [15:0] r_igain;
    logic [15:0] r_gdiv;
    logic [30:0] r_window;
    logic [7:0]  r_dmax;
    logic [7:0]  r_dmin;

    // state
    espc_pkg::t_phase r_phase;
    logic [31:0]        r_last_rise;
    logic [15:0]        r_ovf;
    logic [31:0]        r_period;
    logic [23:0]        r_setpoint;
    logic signed [31:0] r_integral;
    logic [31:0]        r_last_err;
    logic [7:0]         r_duty;
    logic [1:0]         r_bridge;
    logic               r_win;

    // tick pipeline
    logic signed [32:0] r_err;
    logic signed [49:0] r_p1;
    logic signed [48:0] r_p2;
    logic signed [49:0] r_num;
    logic               r_neg;

    logic [31:0]                    cap32;
    logic [31:0]                    stamp;
    logic                           div_busy;
    logic [espc_pkg::DIV_W-1:0]     quot;
    logic [espc_pkg::DIV_W-1:0]     div_dividend;
    logic [31:0]                    div_divisor;
    logic [espc_pkg::STEP_W-1:0]    div_steps;
    logic [31:0]                    speed;
    logic [32:0]                    err_mag;
    logic                           win_now;
    logic                           err_pos;
    logic                           err_neg;
    logic                           integ_en;
    logic signed [33:0]             integ_sum;
    logic [31:0]                    integ_sat;
    logic [31:0]                    err_sat;
    logic signed [16:0]             pgain_s;
    logic signed [16:0]             igain_s;
    logic [49:0]                    num_abs;
    logic [31:0]                    gdiv_eff;
    logic [7:0]                     clamp_hi;
    logic [7:0]                     clamp_lo;

    assign cap32 = {16'd0, i_capture_time} & espc_pkg::CAP_MASK;
    assign stamp = (32'(r_ovf) << espc_pkg::CAPTURE_WIDTH) + cap32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 32'd0;
            r_sgain  <= 16'd1;
            r_pgain  <= 16'd0;
            r_igain  <= 16'd0;
            r_gdiv   <= 16'd1;
            r_window <= 31'd0;
            r_dmax   <= 8'd255;
            r_dmin   <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                espc_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                espc_pkg::CFG_SGAIN:  r_sgain  <= i_cfg_data[15:0];
                espc_pkg::CFG_PGAIN:  r_pgain  <= i_cfg_data[15:0];
                espc_pkg::CFG_IGAIN:  r_igain  <= i_cfg_data[15:0];
                espc_pkg::CFG_DIV:    r_gdiv   <= i_cfg_data[15:0];
                espc_pkg::CFG_WINDOW: r_window <= i_cfg_data[30:0];
                espc_pkg::CFG_DMAX:   r_dmax   <= i_cfg_data[7:0];
                espc_pkg::CFG_DMIN:   r_dmin   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // shared divider: speed = scale / period, then |pi sum| / divisor
    assign num_abs      = r_num[49] ? 50'(-r_num) : 50'(r_num);
    assign gdiv_eff     = (r_gdiv == 16'd0) ? 32'd1 : {16'd0, r_gdiv};
    assign div_dividend = i_cmd.div_drive ? num_abs[espc_pkg::DIV_W-1:0]
                                          : {r_scale, 17'd0};
    assign div_divisor  = i_cmd.div_drive ? gdiv_eff : r_period;
    assign div_steps    = i_cmd.div_drive ? espc_pkg::DRIVE_STEPS : espc_pkg::SPEED_STEPS;

    espc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    assign speed = (r_period == 32'd0) ? 32'd0 : quot[31:0];

    // window test and integrator
    assign err_mag   = r_err[32] ? 33'(-r_err) : 33'(r_err);
    assign win_now   = err_mag < {2'b00, r_window};
    assign err_pos   = !r_err[32] && (r_err != '0);
    assign err_neg   = r_err[32];
    assign integ_en  = (err_pos && (r_duty < r_dmax)) || (err_neg && (r_duty > r_dmin));
    assign integ_sum = 34'(r_integral) + 34'(r_err);
    assign integ_sat = (integ_sum[33] == integ_sum[31]) ? integ_sum[31:0]
                     : (integ_sum[33] ? 32'h8000_0000 : 32'h7fff_ffff);
    assign err_sat   = (r_err[32] == r_err[31]) ? r_err[31:0]
                     : (r_err[32] ? 32'h8000_0000 : 32'h7fff_ffff);

    assign pgain_s = {1'b0, r_pgain};
    assign igain_s = {1'b0, r_igain};

    // clamp: max first, then min
    assign clamp_hi = ((|quot[espc_pkg::DIV_W-1:8]) || (quot[7:0] > r_dmax)) ? r_dmax
                                                                           : quot[7:0];
    assign clamp_lo = (clamp_hi < r_dmin) ? r_dmin : clamp_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= espc_pkg::PH_WAIT;
            r_last_rise <= 32'd0;
            r_ovf       <= 16'd0;
            r_period    <= 32'd0;
            r_setpoint  <= 24'd0;
            r_integral  <= 32'sd0;
            r_last_err  <= 32'd0;
            r_duty      <= 8'd0;
            r_bridge    <= espc_pkg::BR_BRAKE;
            r_win       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                case (i_op)
                    espc_pkg::OP_EDGE: begin
                        case (r_phase)
                            espc_pkg::PH_FALL: begin
                                r_phase <= espc_pkg::PH_RISE;
                            end
                            espc_pkg::PH_RISE: begin
                                r_period    <= stamp - r_last_rise;
                                r_last_rise <= cap32;
                                r_ovf       <= 16'd0;
                                r_phase     <= espc_pkg::PH_FALL;
                            end
                            default: begin
                                r_last_rise <= cap32;
                                r_ovf       <= 16'd0;
                                r_phase     <= espc_pkg::PH_FALL;
                            end
                        endcase
                    end
                    espc_pkg::OP_OVF: begin
                        r_ovf <= r_ovf + 16'd1;
                    end
                    espc_pkg::OP_CMD: begin
                        case (i_direction_cmd)
                            espc_pkg::DIR_FWD:   r_bridge <= espc_pkg::BR_FWD;
                            espc_pkg::DIR_REV:   r_bridge <= espc_pkg::BR_REV;
                            espc_pkg::DIR_BRAKE: r_bridge <= espc_pkg::BR_BRAKE;
                            default: ;
                        endcase
                        r_setpoint <= 24'(i_speed_cmd) * 24'(r_sgain);
                        r_duty     <= espc_pkg::KICK_DUTY;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.win_en) begin
                r_last_err <= err_sat;
                r_win      <= win_now;
                if (win_now && integ_en) begin
                    r_integral <= integ_sat;
                end
            end
            if (i_cmd.clamp_en) begin
                r_duty <= (r_neg && (|quot)) ? r_dmin : clamp_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_en) begin
            r_err <= $signed({9'd0, r_setpoint}) - $signed({1'b0, speed});
        end
        if (i_cmd.mul_en) begin
            r_p1 <= 50'(r_err) * 50'(pgain_s);
            r_p2 <= 49'(r_integral) * 49'(igain_s);
        end
        if (i_cmd.sum_en) begin
            r_num <= r_p1 + 50'(r_p2);
        end
        if (i_cmd.div_start && i_cmd.div_drive) begin
            r_neg <= r_num[49];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_duty         <= r_duty;
            o_bridge_lines <= r_bridge;
            o_period       <= r_period;
            o_speed_error  <= r_last_err;
            o_in_window    <= r_win;
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.win_now  = win_now;

endmodule

@@ src/espc_ctrl.sv @@
// espc_ctrl: sequencer for request handling, control tick steps and result hand-off
// uses espc_pkg; drives espc_dp through its command struct

module espc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_op,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output espc_pkg::t_dp_cmd    o_cmd,
    input  espc_pkg::t_dp_stat   i_stat
);

    espc_pkg::t_state r_state;
    espc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= espc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            espc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == espc_pkg::OP_TICK) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = espc_pkg::S_SPEED;
                    end else begin
                        n_state = espc_pkg::S_EMIT;
                    end
                end
            end
            espc_pkg::S_SPEED: begin
                if (!i_stat.div_busy) begin
                    n_state = espc_pkg::S_ERR;
                end
            end
            espc_pkg::S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = espc_pkg::S_WIN;
            end
            espc_pkg::S_WIN: begin
                o_cmd.win_en = 1'b1;
                n_state      = i_stat.win_now ? espc_pkg::S_MUL : espc_pkg::S_EMIT;
            end
            espc_pkg::S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = espc_pkg::S_SUM;
            end
            espc_pkg::S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = espc_pkg::S_NEG;
            end
            espc_pkg::S_NEG: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_drive = 1'b1;
                n_state         = espc_pkg::S_DRIVE;
            end
            espc_pkg::S_DRIVE: begin
                o_cmd.div_drive = 1'b1;
                if (!i_stat.div_busy) begin
                    n_state = espc_pkg::S_CLAMP;
                end
            end
            espc_pkg::S_CLAMP: begin
                o_cmd.div_drive = 1'b1;
                o_cmd.clamp_en  = 1'b1;
                n_state         = espc_pkg::S_EMIT;
            end
            espc_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = espc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = espc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    assign o_in_stall  = r_state != espc_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

@@ src/encoder_pi_speed_controller.sv @@
// One motor channel: encoder period capture, speed command and PI duty control. Every
// request gives one result holding duty, bridge lines, period, last error and window flag.
// Edge, overflow and command requests go from idle straight to the emit state. A control
// tick runs the speed division and, only with the error inside the window, the PI quotient
// division, on one shared bit-serial divider: 32 steps for speed, 49 for the PI quotient.
// A new request is taken while the previous result still waits in the output register; the
// next result then waits until that one is taken, and input stalls meanwhile.
// Configuration writes are accepted at any time but belong to idle periods.

module encoder_pi_speed_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_capture_time,
    input  logic [1:0]  i_direction_cmd,
    input  logic [7:0]  i_speed_cmd,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_duty,
    output logic [1:0]  o_bridge_lines,
    output logic [31:0] o_period,
    output logic [31:0] o_speed_error,
    output logic        o_in_window,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    espc_pkg::t_dp_cmd  cmd;
    espc_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    espc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    espc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_capture_time  (i_capture_time),
        .i_direction_cmd (i_direction_cmd),
        .i_speed_cmd     (i_speed_cmd),
        .o_duty          (o_duty),
        .o_bridge_lines  (o_bridge_lines),
        .o_period        (o_period),
        .o_speed_error   (o_speed_error),
        .o_in_window     (o_in_window)
    );

`ifndef ASSERT_OFF
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("no busy cycle after an accepted request");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without a request in progress");

    a_bridge_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (|o_bridge_lines))
        else $error("bridge lines both off in a result");
`endif

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for encoder_pi_speed_controller, one motor channel
// a tracker class mirrors period capture, commands and pi duty and checks every status
// depends on espc_pkg and the block itself

module tb_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0]  duty;
        logic [1:0]  bridge;
        logic [31:0] period;
        logic [31:0] err;
        logic        win;
    } t_status;

    class motor_channel_tracker;
        logic [31:0] speed_scale;
        logic [15:0] cmd_gain;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] gain_divisor;
        logic [30:0] error_window;
        logic [7:0]  duty_max;
        logic [7:0]  duty_min;

        espc_pkg::t_phase phase;
        logic [31:0] last_rise;
        logic [15:0] ovf_count;
        logic [31:0] period;
        logic [31:0] setpoint;
        int          integral;
        int          last_err;
        logic [7:0]  duty;
        logic [1:0]  bridge;
        logic        win;

        t_status     status_q[$];
        int          errors;

        function new();
            speed_scale = 32'd0;
            cmd_gain = 16'd1;
            prop_gain = 16'd0;
            integ_gain = 16'd0;
            gain_divisor = 16'd1;
            error_window = 31'd0;
            duty_max = 8'd255;
            duty_min = 8'd0;
            phase = espc_pkg::PH_WAIT;
            last_rise = 32'd0;
            ovf_count = 16'd0;
            period = 32'd0;
            setpoint = 32'd0;
            integral = 0;
            last_err = 0;
            duty = 8'd0;
            bridge = espc_pkg::BR_BRAKE;
            win = 1'b0;
            errors = 0;
        endfunction

        function int sat32(longint v);
            if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
            if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
            return int'(v);
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                espc_pkg::CFG_SCALE:  speed_scale = data;
                espc_pkg::CFG_SGAIN:  cmd_gain = data[15:0];
                espc_pkg::CFG_PGAIN:  prop_gain = data[15:0];
                espc_pkg::CFG_IGAIN:  integ_gain = data[15:0];
                espc_pkg::CFG_DIV:    gain_divisor = data[15:0];
                espc_pkg::CFG_WINDOW: error_window = data[30:0];
                espc_pkg::CFG_DMAX:   duty_max = data[7:0];
                default:              duty_min = data[7:0];
            endcase
        endfunction

        function void take_request(logic [1:0] op, logic [15:0] cap, logic [1:0] dir,
                                   logic [7:0] spd);
            logic [31:0] cap32;
            logic [31:0] stamp_v;
            logic [31:0] speed;
            longint      e;
            longint      mag;
            longint      drive;
            longint      div_v;
            t_status     want;
            case (op)
                espc_pkg::OP_EDGE: begin
                    cap32 = {16'd0, cap} & espc_pkg::CAP_MASK;
                    if (phase == espc_pkg::PH_FALL) begin
                        phase = espc_pkg::PH_RISE;
                    end else if (phase == espc_pkg::PH_RISE) begin
                        stamp_v = 32'({48'd0, ovf_count} << espc_pkg::CAPTURE_WIDTH) + cap32;
                        period = stamp_v - last_rise;
                        last_rise = cap32;
                        ovf_count = 16'd0;
                        phase = espc_pkg::PH_FALL;
                    end else begin
                        last_rise = cap32;
                        ovf_count = 16'd0;
                        phase = espc_pkg::PH_FALL;
                    end
                end
                espc_pkg::OP_OVF: ovf_count = ovf_count + 16'd1;
                espc_pkg::OP_TICK: begin
                    // zero period reads as standstill
                    speed = (period == 32'd0) ? 32'd0 : speed_scale / period;
                    e = longint'({32'd0, setpoint}) - longint'({32'd0, speed});
                    mag = (e < 0) ? -e : e;
                    last_err = sat32(e);
                    win = 1'b0;
                    if (mag < longint'({33'd0, error_window})) begin
                        div_v = (gain_divisor == 16'd0) ? 64'sd1 : longint'({48'd0, gain_divisor});
                        // anti-windup: hold the integral while pushing into a clamp
                        if ((e > 0 && duty < duty_max) || (e < 0 && duty > duty_min))
                            integral = sat32(longint'(integral) + e);
                        drive = (e * longint'({48'd0, prop_gain})
                                 + longint'(integral) * longint'({48'd0, integ_gain})) / div_v;
                        if (drive > longint'({56'd0, duty_max})) drive = longint'({56'd0, duty_max});
                        if (drive < longint'({56'd0, duty_min})) drive = longint'({56'd0, duty_min});
                        duty = drive[7:0];
                        win = 1'b1;
                    end
                end
                default: begin
                    case (dir)
                        espc_pkg::DIR_FWD:   bridge = espc_pkg::BR_FWD;
                        espc_pkg::DIR_REV:   bridge = espc_pkg::BR_REV;
                        espc_pkg::DIR_BRAKE: bridge = espc_pkg::BR_BRAKE;
                        default:   ;
                    endcase
                    setpoint = {24'd0, spd} * {16'd0, cmd_gain};
                    duty = espc_pkg::KICK_DUTY;
                end
            endcase
            want.duty = duty;
            want.bridge = bridge;
            want.period = period;
            want.err = last_err;
            want.win = win;
            status_q.push_back(want);
        endfunction

        function string show(t_status s);
            return $sformatf("duty %0d bridge %0d period %0d error %0d window %0b",
                             s.duty, s.bridge, s.period, $signed(s.err), s.win);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_status(t_status got);
            t_status want;
            if (status_q.size() == 0) begin
                flag({"status with no request waiting: got ", show(got)});
            end else begin
                want = status_q.pop_front();
                if (got.duty !== want.duty || got.bridge !== want.bridge ||
                    got.period !== want.period || got.err !== want.err ||
                    got.win !== want.win)
                    flag({"status mismatch: expected ", show(want), ", got ", show(got)});
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = 2'd0;
    logic [15:0] capture_time = 16'd0;
    logic [1:0]  direction_cmd = 2'd0;
    logic [7:0]  speed_cmd = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  duty;
    logic [1:0]  bridge_lines;
    logic [31:0] period;
    logic [31:0] speed_error;
    logic        in_window;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data = 32'd0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_out = 1'b0;
    logic [31:0] timer_ticks = 32'd0;
    int          quiet = 0;

    motor_channel_tracker tracker = new();

    encoder_pi_speed_controller i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op),
        .i_capture_time  (capture_time),
        .i_direction_cmd (direction_cmd),
        .i_speed_cmd     (speed_cmd),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_duty          (duty),
        .o_bridge_lines  (bridge_lines),
        .o_period        (period),
        .o_speed_error   (speed_error),
        .o_in_window     (in_window),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (hold_out) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_status got;
        got = '{duty, bridge_lines, period, speed_error, in_window};
        if (rst_n && out_valid && !out_stall) tracker.check_status(got);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_req(logic [1:0] r_op, logic [15:0] r_cap, logic [1:0] r_dir,
                            logic [7:0] r_spd);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= r_op;
        capture_time <= r_cap;
        direction_cmd <= r_dir;
        speed_cmd <= r_spd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_request(r_op, r_cap, r_dir, r_spd);
        @(negedge clk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic apply_setting(logic [31:0] scale, logic [15:0] sgain, logic [15:0] pgain,
                                 logic [15:0] igain, logic [15:0] gdiv, logic [30:0] window,
                                 logic [7:0] dmax, logic [7:0] dmin);
        put_reg(espc_pkg::CFG_SCALE, scale);
        put_reg(espc_pkg::CFG_SGAIN, {16'd0, sgain});
        put_reg(espc_pkg::CFG_PGAIN, {16'd0, pgain});
        put_reg(espc_pkg::CFG_IGAIN, {16'd0, igain});
        put_reg(espc_pkg::CFG_DIV, {16'd0, gdiv});
        put_reg(espc_pkg::CFG_WINDOW, {1'b0, window});
        put_reg(espc_pkg::CFG_DMAX, {24'd0, dmax});
        put_reg(espc_pkg::CFG_DMIN, {24'd0, dmin});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_quiet();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // mostly coherent encoder traffic on a running timer, with some junk mixed in
    task automatic send_random_items(int n);
        int          kind;
        logic [31:0] next_ticks;
        repeat (n) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                if ($urandom_range(9) == 0) next_ticks = timer_ticks + $urandom_range(0, 300000);
                else next_ticks = timer_ticks + $urandom_range(1, 20000);
                while (next_ticks[31:16] != timer_ticks[31:16]) begin
                    timer_ticks = {timer_ticks[31:16] + 16'd1, 16'd0};
                    send_req(espc_pkg::OP_OVF, 16'($urandom), 2'($urandom), 8'($urandom));
                end
                timer_ticks = next_ticks;
                send_req(espc_pkg::OP_EDGE, timer_ticks[15:0], 2'($urandom), 8'($urandom));
            end else if (kind < 65) begin
                send_req(espc_pkg::OP_TICK, 16'($urandom), 2'($urandom), 8'($urandom));
            end else if (kind < 80) begin
                send_req(espc_pkg::OP_CMD, 16'($urandom), 2'($urandom),
                         8'($urandom_range(0, 255)));
            end else if (kind < 90) begin
                timer_ticks = {timer_ticks[31:16] + 16'd1, 16'd0};
                send_req(espc_pkg::OP_OVF, 16'($urandom), 2'($urandom), 8'($urandom));
            end else begin
                send_req(2'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero period, keep direction, first edge
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_CMD, 16'h0000, espc_pkg::DIR_KEEP, 8'd0);
        send_req(espc_pkg::OP_EDGE, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        drain_quiet();
        apply_setting(32'd1000000, 16'd4, 16'd3, 16'd1, 16'd16, 31'd100000, 8'd200, 8'd20);

        send_req(espc_pkg::OP_EDGE, 16'hffff, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_OVF, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_OVF, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_EDGE, 16'h1234, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_CMD, 16'h0000, espc_pkg::DIR_FWD, 8'd255);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_CMD, 16'h0000, espc_pkg::DIR_REV, 8'd128);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_CMD, 16'h0000, espc_pkg::DIR_BRAKE, 8'd1);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        // period wrapping below zero, then a zero period
        send_req(espc_pkg::OP_EDGE, 16'h0100, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_EDGE, 16'h0200, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_EDGE, 16'h0300, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_EDGE, 16'h0200, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);
        send_req(espc_pkg::OP_CMD, 16'h0000, espc_pkg::DIR_KEEP, 8'd64);
        send_req(espc_pkg::OP_TICK, 16'h0000, espc_pkg::DIR_FWD, 8'd0);

        for (int ph = 0; ph < 7; ph++) begin
            drain_quiet();
            case (ph)
                4: apply_setting(32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                 31'h7fffffff, 8'd255, 8'd255);
                5: apply_setting(32'd0, 16'd0, 16'd0, 16'd0, 16'd1, 31'd0, 8'd0, 8'd0);
                6: apply_setting($urandom, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 255)), 16'($urandom_range(0, 63)),
                                 16'($urandom_range(1, 65535)), 31'h7fffffff, 8'd10, 8'd200);
                default: apply_setting($urandom, 16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 255)), 16'($urandom_range(0, 63)),
                                       16'($urandom_range(1, 65535)),
                                       31'($urandom_range(0, 32'h7fffffff)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        repeat (50) @(posedge clk);
                        hold_out = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            send_random_items(67);
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

@@ encoder_pi_speed_controller.f @@
src/espc_pkg.sv
src/espc_div.sv
src/espc_dp.sv
src/espc_ctrl.sv
src/encoder_pi_speed_controller.sv
verif/tb_top.sv
